[rtl/core/olib_pkg.sv]
// package for the ordered list insert buffer
// holds field widths, command codes, the request type and defaults
// no dependencies
package olib_pkg;

  localparam int unsigned CapacityDefault = 32;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned PosW            = 6;
  localparam int unsigned IndexW          = 5;

  typedef enum logic [1:0] {
    CMD_FRONT  = 2'd0,
    CMD_AFTER  = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_PLACE  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          pos;
  } req_t;

endpackage

[rtl/core/olib_front.sv]
// front end of the ordered list insert buffer: decodes each request
// and holds it in a two-entry queue for the back end; uses olib_pkg
module olib_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [olib_pkg::ValueW-1:0] item_value_i,
  input  logic [olib_pkg::PosW-1:0]         position_i,
  output olib_pkg::req_t                    req_o,
  output logic                              req_valid_o,
  input  logic                              req_ready_i
);
  import olib_pkg::*;

  req_t       slot_q [2];
  req_t       req_in;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  always_comb begin
    req_in.value = item_value_i;
    req_in.pos   = position_i;
    req_in.op    = OP_CLEAR;
    case (cmd_e'(cmd_i))
      CMD_FRONT: begin
        req_in.op  = OP_PLACE;
        req_in.pos = '0;
      end
      CMD_AFTER: begin
        req_in.op  = OP_PLACE;
        // position zero behaves as one
        req_in.pos = (position_i == '0) ? PosW'(1) : position_i;
      end
      CMD_APPEND: begin
        req_in.op = OP_APPEND;
      end
      default: begin
        req_in.op = OP_CLEAR;
      end
    endcase
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign req_valid_o = (fill_q != 2'd0);
  assign req_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

[rtl/core/olib_back.sv]
// back end of the ordered list insert buffer: the list as a row of
// shifting cells, the insert step and the emission sequencer; uses olib_pkg
module olib_back #(
  parameter int unsigned CAPACITY = olib_pkg::CapacityDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  olib_pkg::req_t                     req_i,
  input  logic                               req_valid_i,
  output logic                               req_ready_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [olib_pkg::ValueW-1:0] element_value_o,
  output logic [olib_pkg::IndexW-1:0]        element_index_o,
  output logic                               last_element_o,
  output logic                               overflow_o
);
  import olib_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CW > PosW) ? CW : PosW;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q, idx_q, count_m1, place;
  logic          over_q;
  logic          out_valid_q, last_q, overflow_q;
  logic signed [ValueW-1:0] value_q;
  logic [IndexW-1:0]        index_q;

  logic [ValueW-1:0] entry_q [CAPACITY];
  logic [ValueW-1:0] entry_d [CAPACITY];
  logic [ValueW-1:0] prev_w  [CAPACITY];
  logic [ValueW-1:0] next_w  [CAPACITY];

  logic take, full, out_free, emit_step, last_step, do_insert;

  assign req_ready_o = (state_q == ST_IDLE);
  assign take        = req_valid_i && req_ready_o;
  assign full        = (count_q == CW'(CAPACITY));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_step   = (state_q == ST_EMIT) && out_free;
  assign count_m1    = count_q - CW'(1);
  assign last_step   = (idx_q == count_m1);
  assign do_insert   = take && (req_i.op != OP_CLEAR) && !full;

  // insert place, clamped to the end of the list
  always_comb begin
    place = count_q;
    if (req_i.op == OP_PLACE) begin
      if (CmpW'(req_i.pos) < CmpW'(count_q)) begin
        place = CW'(req_i.pos);
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
    if (g == 0) begin : g_first
      assign prev_w[g] = entry_q[0];
    end else begin : g_mid
      assign prev_w[g] = entry_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w[g] = entry_q[0];
    end else begin : g_inner
      assign next_w[g] = entry_q[g+1];
    end
  end

  // each cell keeps its own value, takes the new value or the one before it
  // (insert), or takes the one after it (rotate for emission, wrapping at the list end)
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entry_d[i] = entry_q[i];
      if (do_insert) begin
        if (CW'(i) == place) begin
          entry_d[i] = req_i.value;
        end else if ((CW'(i) > place) && (CW'(i) <= count_q)) begin
          entry_d[i] = prev_w[i];
        end
      end else if (emit_step) begin
        if (CW'(i) < count_m1) begin
          entry_d[i] = next_w[i];
        end else if (CW'(i) == count_m1) begin
          entry_d[i] = entry_q[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
      overflow_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !emit_step) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (req_i.op == OP_CLEAR) begin
              count_q <= '0;
            end else begin
              if (full) begin
                over_q <= 1'b1;
              end else begin
                over_q  <= 1'b0;
                count_q <= count_q + CW'(1);
              end
              idx_q   <= '0;
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            value_q     <= entry_q[0];
            index_q     <= IndexW'(idx_q);
            last_q      <= last_step;
            overflow_q  <= over_q;
            idx_q       <= idx_q + CW'(1);
            if (last_step) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign element_value_o = value_q;
  assign element_index_o = index_q;
  assign last_element_o  = last_q;
  assign overflow_o      = overflow_q;

endmodule

[rtl/core/ordered_list_insert_buffer_core.sv]
// top level of the ordered list insert buffer
// joins olib_front and olib_back through the request queue; uses olib_pkg
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o  | cmd_i, item_value_i, position_i
//  out     | output    | out_valid_o/out_stall_i| element_value_o, element_index_o,
//          |           |                        | last_element_o, overflow_o
//
// an insert request is taken by the back end, then the list is
// emitted one element a cycle while out_stall_i is low
// a clear emits nothing
// the front queue holds two requests, so up to two can wait there while
// the emission sequencer waits on out_stall_i
// reset empties the list; entry contents stay undefined until written
module ordered_list_insert_buffer_core #(
  parameter int unsigned CAPACITY = olib_pkg::CapacityDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         cmd_i,
  input  logic signed [olib_pkg::ValueW-1:0] item_value_i,
  input  logic [olib_pkg::PosW-1:0]          position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [olib_pkg::ValueW-1:0] element_value_o,
  output logic [olib_pkg::IndexW-1:0]        element_index_o,
  output logic                               last_element_o,
  output logic                               overflow_o
);
  import olib_pkg::*;

  req_t req;
  logic req_valid, req_ready;

  olib_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .item_value_i (item_value_i),
    .position_i   (position_i),
    .req_o        (req),
    .req_valid_o  (req_valid),
    .req_ready_i  (req_ready)
  );

  olib_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .req_valid_i     (req_valid),
    .req_ready_o     (req_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_value_o (element_value_o),
    .element_index_o (element_index_o),
    .last_element_o  (last_element_o),
    .overflow_o      (overflow_o)
  );

`ifndef SYNTHESIS
  // indexes count up within a run
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_element_o) |=>
      (!out_valid_o || element_index_o == IndexW'($past(element_index_o) + 5'd1)))
    else $error("element index did not advance within a run");

  // a new run starts at index zero
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_element_o) |=>
      (!out_valid_o || element_index_o == '0))
    else $error("run did not start at index zero");

  // overflow flag holds over a whole run
  a_over_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_element_o) |=>
      (!out_valid_o || overflow_o == $past(overflow_o)))
    else $error("overflow flag changed within a run");

  // an overflow run covers the full list
  a_over_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o && last_element_o) |->
      (element_index_o == IndexW'(CAPACITY - 1)))
    else $error("overflow run shorter than capacity");
`endif

endmodule

[tb/sv/ordered_list_insert_buffer_core_tb.sv]
// testbench for ordered_list_insert_buffer_core: random and directed list commands,
// each emitted run checked element by element against a tracked copy of the list
// depends on olib_pkg and the ordered_list_insert_buffer_core rtl
module ordered_list_insert_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olib_pkg::*;

  localparam int unsigned Capacity   = CapacityDefault;
  localparam int unsigned ItemTarget = 320;
  localparam int unsigned CycleLimit = 1200000;
  localparam int unsigned DrainWait  = Capacity + 8;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        index;
    logic                     last;
    logic                     over;
  } element_t;

  class list_tracker;
    logic signed [ValueW-1:0] list_copy[$];
    element_t                 pending_elements[$];
    int unsigned              errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned size();
      return list_copy.size();
    endfunction

    function int unsigned pending();
      return pending_elements.size();
    endfunction

    // update the list for one accepted request and queue the run it emits
    function void apply_request(cmd_e cmd, logic signed [ValueW-1:0] value,
                                logic [PosW-1:0] pos);
      int unsigned place;
      logic        over;
      element_t    e;
      over = 1'b0;
      place = 0;
      if (cmd == CMD_CLEAR) begin
        list_copy.delete();
        return;
      end
      if (list_copy.size() >= Capacity) begin
        over = 1'b1;
      end else begin
        case (cmd)
          CMD_FRONT: place = 0;
          CMD_AFTER: place = (pos == 0) ? 1 : pos;
          default:   place = list_copy.size();
        endcase
        // past the end or on an empty list the insert becomes an append
        if (place > list_copy.size()) place = list_copy.size();
        list_copy.insert(place, value);
      end
      foreach (list_copy[k]) begin
        e.value = list_copy[k];
        e.index = IndexW'(k);
        e.last  = (k == list_copy.size() - 1);
        e.over  = over;
        pending_elements.push_back(e);
      end
    endfunction

    function void check_element(logic signed [ValueW-1:0] value, logic [IndexW-1:0] index,
                                logic last, logic over);
      element_t e;
      if (pending_elements.size() == 0) begin
        errors++;
        $display("%0t: unexpected element: value %0d index %0d last %0b overflow %0b",
                 $time, value, index, last, over);
        return;
      end
      e = pending_elements.pop_front();
      if (value !== e.value || index !== e.index || last !== e.last || over !== e.over) begin
        errors++;
        $display("%0t: element mismatch: expected value %0d index %0d last %0b overflow %0b",
                 $time, e.value, e.index, e.last, e.over);
        $display("%0t:                   actual   value %0d index %0d last %0b overflow %0b",
                 $time, value, index, last, over);
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               cmd_i;
  logic signed [ValueW-1:0] item_value_i;
  logic [PosW-1:0]          position_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [ValueW-1:0] element_value_o;
  logic [IndexW-1:0]        element_index_o;
  logic                     last_element_o;
  logic                     overflow_o;

  list_tracker tracker = new();
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet_mode = 1'b0;

  ordered_list_insert_buffer_core #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .item_value_i   (item_value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .element_value_o(element_value_o),
    .element_index_o(element_index_o),
    .last_element_o (last_element_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // output side stalls: mostly short bursts, now and then a long one
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(9, 19)
                                                  : $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_element(element_value_o, element_index_o, last_element_o, overflow_o);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // half the positions land inside or just past the current list
  function automatic logic [PosW-1:0] pick_pos();
    int unsigned hi;
    hi = tracker.size() + 1;
    if (hi > 32) hi = 32;
    if ($urandom_range(0, 1) == 0) return PosW'($urandom_range(0, hi));
    return PosW'($urandom_range(0, 32));
  endfunction

  task automatic send_request(cmd_e cmd, logic signed [ValueW-1:0] value,
                              logic [PosW-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    item_value_i <= value;
    position_i   <= pos;
    do @(posedge clk_i); while (in_stall_o);
    tracker.apply_request(cmd, value, pos);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned fill;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    cmd_i        <= CMD_FRONT;
    item_value_i <= '0;
    position_i   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clear on an empty list, then each insert kind on an empty list
    send_request(CMD_CLEAR, 32'sh1234_5678, 6'd17);
    send_request(CMD_FRONT, 32'sh7fff_ffff, 6'd0);
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_AFTER, -32'sd5, 6'd5);
    send_request(CMD_CLEAR, '1, 6'd32);
    send_request(CMD_APPEND, 32'sh8000_0000, 6'd0);
    send_request(CMD_FRONT, '1, 6'd31);
    send_request(CMD_AFTER, '0, 6'd0);                // zero acts as one
    send_request(CMD_AFTER, 32'sd1, 6'd1);
    send_request(CMD_AFTER, 32'sh5555_5555, 6'd32);   // past the end
    send_request(CMD_AFTER, 32'shaaaa_aaaa, 6'd3);
    send_request(CMD_AFTER, 32'sd77, 6'd6);           // exactly at the end
    send_request(CMD_APPEND, 32'sh0f0f_0f0f, 6'd32);
    send_request(CMD_FRONT, 32'shf0f0_f0f0, 6'd21);
    send_request(CMD_AFTER, 32'sd42, 6'd10);

    // fill up to capacity, then overflow with every insert kind
    send_request(CMD_CLEAR, '0, '0);
    for (int i = 0; i < Capacity; i++) begin
      send_request(cmd_e'($urandom_range(0, 2)), pick_value(), pick_pos());
    end
    send_request(CMD_FRONT, 32'sd100, 6'd0);
    send_request(CMD_AFTER, 32'sd101, 6'd4);
    send_request(CMD_APPEND, 32'sd102, 6'd32);
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_APPEND, 32'sd7, 6'd0);

    // hold the sender back until the output side has caught up
    in_valid_i <= 1'b0;
    wait_drained();
    @(posedge clk_i);

    while (items_sent < ItemTarget) begin
      quiet_mode = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // build a list from scratch, sometimes past capacity
          send_request(CMD_CLEAR, pick_value(), pick_pos());
          fill = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 38)
                                              : $urandom_range(1, 12);
          for (int i = 0; i < fill; i++) begin
            send_request(cmd_e'($urandom_range(0, 2)), pick_value(), pick_pos());
          end
        end
        6, 7, 8: begin
          // keep growing whatever list is there
          fill = $urandom_range(1, 6);
          for (int i = 0; i < fill; i++) begin
            send_request(cmd_e'($urandom_range(0, 2)), pick_value(), pick_pos());
          end
        end
        default: begin
          // noise, clears included
          fill = $urandom_range(1, 4);
          for (int i = 0; i < fill; i++) begin
            send_request(cmd_e'($urandom_range(0, 3)), $urandom,
                         PosW'($urandom_range(0, 32)));
          end
        end
      endcase
    end
    quiet_mode = 1'b0;
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/olib_pkg.sv
rtl/core/olib_front.sv
rtl/core/olib_back.sv
rtl/core/ordered_list_insert_buffer_core.sv
tb/sv/ordered_list_insert_buffer_core_tb.sv
